// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define DLCD_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define DLCD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define DLCD_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dlcd_pkg.sv
// Shared widths, register codes, constants and types of the detent lock current drive.
`timescale 1ns / 1ps
package dlcd_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  localparam int SIZE_W  = 15;
  localparam int BAND_W  = 10;
  localparam int GAIN_W  = 6;
  localparam int RAW_W   = 12;
  localparam int SPEED_W = 16;
  localparam int OFF_W   = 16;
  localparam int TGT_W   = 20;
  localparam int VOLT_W  = 16;
  localparam int MEAS_W  = 14;
  localparam int HALF_W  = SIZE_W - 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DETENT_SIZE   = 2'd0,
    CFG_POSITION_BAND = 2'd1,
    CFG_SPEED_BAND    = 2'd2,
    CFG_CURRENT_GAIN  = 2'd3
  } cfg_reg_t;

  localparam logic [SIZE_W-1:0] DETENT_SIZE_RST   = 15'd718;
  localparam logic [BAND_W-1:0] POSITION_BAND_RST = 10'd22;
  localparam logic [BAND_W-1:0] SPEED_BAND_RST    = 10'd10;
  localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST  = 6'd8;
  localparam logic [SIZE_W-1:0] DETENT_SIZE_MIN   = 15'd2;

  // Converter scale, 0.000634921 A per step in units of 2^-28 A (Q16 of the 2^-12 A unit), and its rounding half.
  localparam logic [17:0] MEAS_COEF = 18'd170435;
  localparam logic [16:0] MEAS_HALF = 17'd32768;

  // Profile thresholds on the offset magnitude.
  localparam logic [SIZE_W-1:0] DEAD_LIM  = 15'd15;
  localparam logic [SIZE_W-1:0] EDGE_LIM  = 15'd22;
  localparam logic [SIZE_W-1:0] SLOPE_LIM = 15'd500;

  // Slope: 0.53 A and 2.41e-7 A per count in units of 2^-32 A.
  localparam logic [31:0] C053_Q32  = 32'd2276332667;
  localparam logic [10:0] K2_Q32    = 11'd1035;
  localparam logic [32:0] SLOPE_RND = 33'd524288;

  // Far region: (|d| * 6144 + 50) / 100 by a reciprocal, exact below 2^27.
  localparam logic [12:0] FAR_GAIN  = 13'd6144;
  localparam logic [6:0]  FAR_RND   = 7'd50;
  localparam logic [27:0] FAR_MAGIC = 28'd171798692;
  localparam int          FAR_SHIFT = 34;

  localparam logic signed [TGT_W-1:0]  EDGE_CUR = 20'sd1843;
  localparam logic signed [TGT_W-1:0]  TGT_MAX  = 20'sd524287;
  localparam logic signed [TGT_W-1:0]  TGT_MIN  = -20'sd524288;
  localparam logic [TGT_W-1:0]         TGT_MAX_MAG = 20'd524287;
  localparam logic [TGT_W-1:0]         TGT_MIN_MAG = 20'd524288;
  localparam logic signed [VOLT_W-1:0] VOLT_MAX = 16'sd20439;

  // Side information that rides alongside the divider.
  typedef struct packed {
    logic              neg;
    logic              spd_ok;
    logic [MEAS_W-1:0] meas;
  } dlcd_side_t;

endpackage

// File: rtl/dlcd_ifs.sv
// Sample and result channel interfaces of the detent lock current drive.
`timescale 1ns / 1ps
interface dlcd_sample_if #(
  parameter int COUNT_WIDTH = dlcd_pkg::COUNT_WIDTH_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic signed [COUNT_WIDTH-1:0]          encoder_count;
  logic signed [dlcd_pkg::SPEED_W-1:0]    speed_sample;
  logic        [dlcd_pkg::RAW_W-1:0]      current_raw;

  modport source (output valid, encoder_count, speed_sample, current_raw, input ready);
  modport sink   (input valid, encoder_count, speed_sample, current_raw, output ready);
endinterface

interface dlcd_result_if #(
  parameter int COUNT_WIDTH = dlcd_pkg::COUNT_WIDTH_DEF
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COUNT_WIDTH-1:0]        detent_index;
  logic signed [COUNT_WIDTH-1:0]        detent_offset;
  logic signed [dlcd_pkg::TGT_W-1:0]    current_target;
  logic signed [dlcd_pkg::VOLT_W-1:0]   drive_voltage;
  logic                                 locked;

  modport source (output valid, detent_index, detent_offset, current_target,
                  drive_voltage, locked, input ready);
  modport sink   (input valid, detent_index, detent_offset, current_target,
                  drive_voltage, locked, output ready);
endinterface

// File: rtl/detent_lock_current_drive_top.sv
// Top level of the detent lock current drive: registers, detent mapping, profile and drive law.
`timescale 1ns / 1ps
// Takes one sample word per cycle unless held back by a stalled result, and gives one
// result word per sample, in order. The path is one input register, then the detent
// divider, which resolves one quotient bit per pipeline stage, then six stages for the
// offset, the current profile and the drive law. Every stage has its own valid bit and
// a stage takes a new word whenever it is empty or its successor moves, so a stalled
// result only holds back the input once the pipeline has no bubbles left.
// Configuration registers are written through cfg_we, cfg_index and cfg_data and
// should only change while no sample is in flight. A detent size below two is used
// as two. The index and offset are wrapped to COUNT_WIDTH bits; the profile target
// is in 2^-12 A and the drive voltage in 2^-12 V, saturated to plus or minus 4.99 V.
module detent_lock_current_drive_top #(
  parameter int COUNT_WIDTH = dlcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dlcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dlcd_pkg::CFG_DATA_W-1:0]   cfg_data,
  dlcd_sample_if.sink                       sample,
  dlcd_result_if.source                     result
);

  localparam int SIZE_W = dlcd_pkg::SIZE_W;
  localparam int HALF_W = dlcd_pkg::HALF_W;
  localparam int OFF_W  = dlcd_pkg::OFF_W;
  localparam int TGT_W  = dlcd_pkg::TGT_W;
  localparam int MEAS_W = dlcd_pkg::MEAS_W;
  localparam int NW     = ((COUNT_WIDTH > SIZE_W) ? COUNT_WIDTH : SIZE_W) + 1;
  localparam int UW     = NW - 1;
  localparam int PW     = TGT_W + 1 + dlcd_pkg::GAIN_W + 1;

  typedef enum logic [1:0] {
    REG_DEAD,
    REG_EDGE,
    REG_SLOPE,
    REG_FAR
  } region_t;

  // Configuration registers.
  logic [SIZE_W-1:0]             detent_size;
  logic [dlcd_pkg::BAND_W-1:0]   position_band;
  logic [dlcd_pkg::BAND_W-1:0]   speed_band;
  logic [dlcd_pkg::GAIN_W-1:0]   current_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      detent_size   <= dlcd_pkg::DETENT_SIZE_RST;
      position_band <= dlcd_pkg::POSITION_BAND_RST;
      speed_band    <= dlcd_pkg::SPEED_BAND_RST;
      current_gain  <= dlcd_pkg::CURRENT_GAIN_RST;
    end else if (cfg_we) begin
      case (dlcd_pkg::cfg_reg_t'(cfg_index))
        dlcd_pkg::CFG_DETENT_SIZE:   detent_size   <= cfg_data[SIZE_W-1:0];
        dlcd_pkg::CFG_POSITION_BAND: position_band <= cfg_data[dlcd_pkg::BAND_W-1:0];
        dlcd_pkg::CFG_SPEED_BAND:    speed_band    <= cfg_data[dlcd_pkg::BAND_W-1:0];
        dlcd_pkg::CFG_CURRENT_GAIN:  current_gain  <= cfg_data[dlcd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] size_eff;
  logic [HALF_W-1:0] half;

  assign size_eff = (detent_size < dlcd_pkg::DETENT_SIZE_MIN) ? dlcd_pkg::DETENT_SIZE_MIN
                                                              : detent_size;
  assign half     = size_eff[SIZE_W-1:1];

  // Ready chain, from the output back to the input.
  logic va, vb, vc1, vc2, vc3, vd1, vo;
  logic ra, rb, rc1, rc2, rc3, rd1, ro;
  logic div_in_ready, div_out_valid;

  assign ro  = !vo  || result.ready;
  assign rd1 = !vd1 || ro;
  assign rc3 = !vc3 || rd1;
  assign rc2 = !vc2 || rc3;
  assign rc1 = !vc1 || rc2;
  assign rb  = !vb  || rc1;
  assign ra  = !va  || div_in_ready;

  assign sample.ready = ra;

  // Stage A: bias the count by half a detent and fold negatives so that the
  // divider only sees a non-negative dividend; floor(n/s) = ~floor(~n/s) for n < 0.
  logic signed [NW-1:0]          n_wide;
  logic [UW-1:0]                 u_next;
  logic signed [dlcd_pkg::SPEED_W:0] spd_ext;
  logic [dlcd_pkg::SPEED_W:0]    spd_abs;
  logic [30:0]                   meas_full;
  dlcd_pkg::dlcd_side_t          side_next;

  assign n_wide  = NW'(sample.encoder_count) + NW'($signed({1'b0, half}));
  assign u_next  = n_wide[NW-1] ? ~n_wide[UW-1:0] : n_wide[UW-1:0];
  assign spd_ext = (dlcd_pkg::SPEED_W + 1)'(sample.speed_sample);
  assign spd_abs = spd_ext[dlcd_pkg::SPEED_W] ? $unsigned(-spd_ext) : $unsigned(spd_ext);
  assign meas_full = 31'(sample.current_raw) * 31'(dlcd_pkg::MEAS_COEF)
                   + 31'(dlcd_pkg::MEAS_HALF);

  assign side_next.neg    = n_wide[NW-1];
  assign side_next.spd_ok = spd_abs <= (dlcd_pkg::SPEED_W + 1)'(speed_band);
  assign side_next.meas   = meas_full[29:16];

  logic [UW-1:0]        a_u;
  dlcd_pkg::dlcd_side_t a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ra) begin
      va <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ra && sample.valid) begin
      a_u    <= u_next;
      a_side <= side_next;
    end
  end

  // Detent divider.
  logic [UW-1:0]        q;
  logic [SIZE_W-1:0]    rem;
  dlcd_pkg::dlcd_side_t q_side;

  dlcd_div #(
    .UW (UW)
  ) u_div (
    .clk         (clk),
    .rst         (rst),
    .divisor     (size_eff),
    .in_valid    (va),
    .in_ready    (div_in_ready),
    .in_dividend (a_u),
    .in_side     (a_side),
    .out_valid   (div_out_valid),
    .out_ready   (rb),
    .out_quot    (q),
    .out_rem     (rem),
    .out_side    (q_side)
  );

  // Stage B: index and offset. For a folded dividend the floor remainder is s-1-rem.
  logic [SIZE_W-1:0]       r_pos;
  logic signed [OFF_W-1:0] off_next;
  logic [NW-1:0]           idx_next;

  assign r_pos    = q_side.neg ? SIZE_W'(size_eff - SIZE_W'(1) - rem) : rem;
  assign off_next = $signed({1'b0, r_pos}) - $signed({2'b00, half});
  assign idx_next = q_side.neg ? ~{1'b0, q} : {1'b0, q};

  logic [NW-1:0]           b_idx;
  logic signed [OFF_W-1:0] b_off;
  logic [MEAS_W-1:0]       b_meas;
  logic                    b_spd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rb) begin
      vb <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && div_out_valid) begin
      b_idx    <= idx_next;
      b_off    <= off_next;
      b_meas   <= q_side.meas;
      b_spd_ok <= q_side.spd_ok;
    end
  end

  // Stage C1: region, slope product, far-region numerator and lock test.
  logic [OFF_W-1:0]  ad_w;
  logic [SIZE_W-1:0] ad;
  region_t           region_next;
  logic [9:0]        slope_dist;
  logic [19:0]       slope_prod_next;
  logic [26:0]       far_x_next;

  assign ad_w = b_off[OFF_W-1] ? $unsigned(-b_off) : $unsigned(b_off);
  assign ad   = ad_w[SIZE_W-1:0];
  assign slope_dist = 10'(ad_w + OFF_W'(dlcd_pkg::EDGE_LIM));
  assign slope_prod_next = 20'(20'(slope_dist) * 20'(dlcd_pkg::K2_Q32));
  assign far_x_next = 27'(27'(ad) * 27'(dlcd_pkg::FAR_GAIN) + 27'(dlcd_pkg::FAR_RND));

  always_comb begin
    if (ad <= dlcd_pkg::DEAD_LIM) begin
      region_next = REG_DEAD;
    end else if (ad <= dlcd_pkg::EDGE_LIM) begin
      region_next = REG_EDGE;
    end else if (ad < dlcd_pkg::SLOPE_LIM) begin
      region_next = REG_SLOPE;
    end else begin
      region_next = REG_FAR;
    end
  end

  logic [NW-1:0]           c1_idx;
  logic signed [OFF_W-1:0] c1_off;
  logic [MEAS_W-1:0]       c1_meas;
  logic                    c1_lock;
  region_t                 c1_region;
  logic [19:0]             c1_prod;
  logic [26:0]             c1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc1 <= 1'b0;
    end else if (rc1) begin
      vc1 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (rc1 && vb) begin
      c1_idx    <= b_idx;
      c1_off    <= b_off;
      c1_meas   <= b_meas;
      c1_lock   <= (ad <= SIZE_W'(position_band)) && b_spd_ok;
      c1_region <= region_next;
      c1_prod   <= slope_prod_next;
      c1_x      <= far_x_next;
    end
  end

  // Stage C2: slope magnitude rounded half up, far magnitude by reciprocal.
  logic [32:0] slope_sum;
  logic [54:0] far_prod;

  assign slope_sum = 33'(dlcd_pkg::C053_Q32) - 33'(c1_prod) + dlcd_pkg::SLOPE_RND;
  assign far_prod  = 55'(c1_x) * 55'(dlcd_pkg::FAR_MAGIC);

  logic [NW-1:0]           c2_idx;
  logic signed [OFF_W-1:0] c2_off;
  logic [MEAS_W-1:0]       c2_meas;
  logic                    c2_lock;
  region_t                 c2_region;
  logic [11:0]             c2_sm;
  logic [TGT_W-1:0]        c2_fmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc2 <= 1'b0;
    end else if (rc2) begin
      vc2 <= vc1;
    end
  end

  always_ff @(posedge clk) begin
    if (rc2 && vc1) begin
      c2_idx    <= c1_idx;
      c2_off    <= c1_off;
      c2_meas   <= c1_meas;
      c2_lock   <= c1_lock;
      c2_region <= c1_region;
      c2_sm     <= slope_sum[31:20];
      c2_fmag   <= far_prod[dlcd_pkg::FAR_SHIFT + TGT_W - 1:dlcd_pkg::FAR_SHIFT];
    end
  end

  // Stage C3: signed, saturated target current.
  logic                    d_neg;
  logic signed [TGT_W:0]   fneg;
  logic signed [TGT_W-1:0] sm_s;
  logic signed [TGT_W-1:0] tgt_next;

  assign d_neg = c2_off[OFF_W-1];
  assign fneg  = -$signed({1'b0, c2_fmag});
  assign sm_s  = $signed(TGT_W'(c2_sm));

  always_comb begin
    case (c2_region)
      REG_DEAD:  tgt_next = '0;
      REG_EDGE:  tgt_next = d_neg ? dlcd_pkg::EDGE_CUR : -dlcd_pkg::EDGE_CUR;
      REG_SLOPE: tgt_next = d_neg ? -sm_s : sm_s;
      REG_FAR: begin
        if (d_neg) begin
          tgt_next = (c2_fmag > dlcd_pkg::TGT_MAX_MAG) ? dlcd_pkg::TGT_MAX
                                                      : $signed(c2_fmag);
        end else begin
          tgt_next = (c2_fmag > dlcd_pkg::TGT_MIN_MAG) ? dlcd_pkg::TGT_MIN
                                                      : fneg[TGT_W-1:0];
        end
      end
      default:   tgt_next = '0;
    endcase
  end

  logic [NW-1:0]           c3_idx;
  logic signed [OFF_W-1:0] c3_off;
  logic [MEAS_W-1:0]       c3_meas;
  logic                    c3_lock;
  logic signed [TGT_W-1:0] c3_tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc3 <= 1'b0;
    end else if (rc3) begin
      vc3 <= vc2;
    end
  end

  always_ff @(posedge clk) begin
    if (rc3 && vc2) begin
      c3_idx  <= c2_idx;
      c3_off  <= c2_off;
      c3_meas <= c2_meas;
      c3_lock <= c2_lock;
      c3_tgt  <= tgt_next;
    end
  end

  // Stage D1: current error times gain.
  logic signed [TGT_W:0] cur_err;
  logic signed [PW-1:0]  volt_prod_next;

  assign cur_err = (TGT_W + 1)'(c3_tgt) - $signed((TGT_W + 1)'(c3_meas));
  assign volt_prod_next = PW'(cur_err) * PW'($signed({1'b0, current_gain}));

  logic [NW-1:0]           d1_idx;
  logic signed [OFF_W-1:0] d1_off;
  logic                    d1_lock;
  logic signed [TGT_W-1:0] d1_tgt;
  logic signed [PW-1:0]    d1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0;
    end else if (rd1) begin
      vd1 <= vc3;
    end
  end

  always_ff @(posedge clk) begin
    if (rd1 && vc3) begin
      d1_idx  <= c3_idx;
      d1_off  <= c3_off;
      d1_lock <= c3_lock;
      d1_tgt  <= c3_tgt;
      d1_prod <= volt_prod_next;
    end
  end

  // Output register: voltage saturation.
  logic signed [dlcd_pkg::VOLT_W-1:0] volt_next;

  always_comb begin
    if (d1_prod > PW'(dlcd_pkg::VOLT_MAX)) begin
      volt_next = dlcd_pkg::VOLT_MAX;
    end else if (d1_prod < -PW'(dlcd_pkg::VOLT_MAX)) begin
      volt_next = -dlcd_pkg::VOLT_MAX;
    end else begin
      volt_next = d1_prod[dlcd_pkg::VOLT_W-1:0];
    end
  end

  logic [COUNT_WIDTH-1:0]             o_idx;
  logic signed [COUNT_WIDTH-1:0]      o_off;
  logic signed [TGT_W-1:0]            o_tgt;
  logic signed [dlcd_pkg::VOLT_W-1:0] o_volt;
  logic                               o_lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (ro) begin
      vo <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ro && vd1) begin
      o_idx  <= d1_idx[COUNT_WIDTH-1:0];
      o_off  <= COUNT_WIDTH'(d1_off);
      o_tgt  <= d1_tgt;
      o_volt <= volt_next;
      o_lock <= d1_lock;
    end
  end

  assign result.valid          = vo;
  assign result.detent_index   = $signed(o_idx);
  assign result.detent_offset  = o_off;
  assign result.current_target = o_tgt;
  assign result.drive_voltage  = o_volt;
  assign result.locked         = o_lock;

endmodule

// File: rtl/dlcd_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side information.
`timescale 1ns / 1ps
module dlcd_div #(
  parameter int UW = dlcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [dlcd_pkg::SIZE_W-1:0]   divisor,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [UW-1:0]                 in_dividend,
  input  dlcd_pkg::dlcd_side_t          in_side,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [UW-1:0]                 out_quot,
  output logic [dlcd_pkg::SIZE_W-1:0]   out_rem,
  output dlcd_pkg::dlcd_side_t          out_side
);

  localparam int SW = dlcd_pkg::SIZE_W;

  logic                 vld  [UW];
  logic [UW:0]          rdy;
  logic [SW-1:0]        rem  [UW];
  logic [UW-1:0]        dq   [UW];
  dlcd_pkg::dlcd_side_t side [UW];

  assign rdy[UW] = out_ready;

  // Each stage shifts one dividend bit into the partial remainder and
  // shifts the quotient bit in where the dividend bit left.
  for (genvar k = 0; k < UW; k++) begin : g_stage
    logic                 prev_v;
    logic [SW-1:0]        prev_rem;
    logic [UW-1:0]        prev_dq;
    dlcd_pkg::dlcd_side_t prev_side;
    logic [SW:0]          trial;
    logic                 ge;

    if (k == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rem  = '0;
      assign prev_dq   = in_dividend;
      assign prev_side = in_side;
    end else begin : g_rest
      assign prev_v    = vld[k-1];
      assign prev_rem  = rem[k-1];
      assign prev_dq   = dq[k-1];
      assign prev_side = side[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];
    assign trial  = {prev_rem, prev_dq[UW-1]};
    assign ge     = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && prev_v) begin
        rem[k]  <= ge ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
        dq[k]   <= {prev_dq[UW-2:0], ge};
        side[k] <= prev_side;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[UW-1];
  assign out_quot  = dq[UW-1];
  assign out_rem   = rem[UW-1];
  assign out_side  = side[UW-1];

endmodule

// File: rtl/dlcd_checker.sv
// Port-level checker for the detent lock current drive, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dlcd_checker #(
  parameter int COUNT_WIDTH = dlcd_pkg::COUNT_WIDTH_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [COUNT_WIDTH-1:0]      detent_index,
  input logic signed [COUNT_WIDTH-1:0]      detent_offset,
  input logic signed [dlcd_pkg::TGT_W-1:0]  current_target,
  input logic signed [dlcd_pkg::VOLT_W-1:0] drive_voltage,
  input logic                               locked
);

  // A result word waiting on the sink must not change.
  `DLCD_ASSERT_NEXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(detent_index) && $stable(detent_offset) && $stable(current_target) && $stable(drive_voltage) && $stable(locked), "result word changed while stalled")

  // No result word straight out of reset.
  `DLCD_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

  // The drive voltage stays within its saturation limits.
  `DLCD_ASSERT_IMPLY(a_volt_range, clk, rst, out_valid, drive_voltage <= dlcd_pkg::VOLT_MAX && drive_voltage >= -dlcd_pkg::VOLT_MAX, "drive voltage beyond saturation")

  // Locked can only be reported with an offset inside the widest position band.
  `DLCD_ASSERT_IMPLY(a_lock_band, clk, rst, out_valid && locked, int'(detent_offset) <= 1023 && int'(detent_offset) >= -1023, "locked with offset outside any band")

  // Inside the dead zone the target current is zero, when the offset is not wrapped.
  `DLCD_ASSERT_IMPLY(a_dead_zone, clk, rst, out_valid && COUNT_WIDTH >= 16 && int'(detent_offset) <= 15 && int'(detent_offset) >= -15, current_target == '0, "non-zero target in dead zone")

endmodule

bind detent_lock_current_drive_top dlcd_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_dlcd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .detent_index   (result.detent_index),
  .detent_offset  (result.detent_offset),
  .current_target (result.current_target),
  .drive_voltage  (result.drive_voltage),
  .locked         (result.locked)
);
